FILE: rtl/pcpa_pkg.sv
// Shared constants, types and helpers of the per-CPU page and superpage allocator.
package pcpa_pkg;

    // Default sizes
    localparam int PCPA_NUM_CPUS  = 8;
    localparam int PCPA_NUM_PAGES = 32768;
    localparam int PCPA_NUM_SUPER = 16;

    // Block sizes (powers of two)
    localparam longint PAGE_BYTES  = 4096;
    localparam longint SUPER_BYTES = 2097152;
    localparam int     PAGE_SH     = $clog2(PAGE_BYTES);
    localparam int     SUPER_SH    = $clog2(SUPER_BYTES);

    // Pool end is kept wide enough to never wrap
    localparam int POOL_W = 40;

    // Request kinds
    localparam logic [1:0] REQ_PAGE_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_PAGE_FREE   = 2'd1;
    localparam logic [1:0] REQ_SUPER_ALLOC = 2'd2;
    localparam logic [1:0] REQ_SUPER_FREE  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_BAD_PAGE = 3'd2;
    localparam logic [2:0] ST_IN_POOL  = 3'd3;
    localparam logic [2:0] ST_INACTIVE = 3'd4;
    localparam logic [2:0] ST_OUT_POOL = 3'd5;
    localparam logic [2:0] ST_MISALIGN = 3'd6;
    localparam logic [2:0] ST_DOUBLE   = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_MEM_BASE     = 3'd0;
    localparam logic [2:0] CFG_KERNEL_END   = 3'd1;
    localparam logic [2:0] CFG_PHYS_TOP     = 3'd2;
    localparam logic [2:0] CFG_SUPER_START  = 3'd3;
    localparam logic [2:0] CFG_SUPER_ACTIVE = 3'd4;

    // Superpage pool answer for the current item
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] addr;
    } pcpa_sup_res_t;

    // CPU number folded into range by repeated subtraction (3-bit value)
    function automatic logic [2:0] cpu_fold(input logic [2:0] c, input int n);
        logic [2:0] v;
        v = c;
        for (int k = 0; k < 8; k++) begin
            if (int'(v) >= n) begin
                v = 3'(int'(v) - n);
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/percpu_page_and_superpage_allocator_unit.sv
// Top level: per-CPU page free lists with stealing, plus the superpage pool.
// Flow: an item is taken in S_IDLE and its result is registered in S_EXEC; a page alloc that
// finds a page goes on to S_LINK for the next-link read and registers its result there.
// One item is worked at a time.
// A waiting result stalls the item in flight and so keeps intake closed.
// Reset (synchronous, aresetn low): lists empty, all superpages free, config to defaults.
module percpu_page_and_superpage_allocator_unit
    import pcpa_pkg::*;
#(
    parameter int NUM_CPUS  = PCPA_NUM_CPUS,
    parameter int NUM_PAGES = PCPA_NUM_PAGES,
    parameter int NUM_SUPER = PCPA_NUM_SUPER
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] cpu, [34:3] addr, [39:35] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_addr, [34:32] status, [39:35] zero
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam logic [POOL_W-1:0] POOL_SPAN = POOL_W'(NUM_SUPER) * POOL_W'(SUPER_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    // configuration registers
    logic [31:0] mem_base_reg;
    logic [31:0] kernel_end_reg;
    logic [31:0] phys_top_reg;
    logic [31:0] super_start_reg;
    logic        super_active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_base_reg     <= 32'h8000_0000;
            kernel_end_reg   <= 32'h8002_0000;
            phys_top_reg     <= 32'h8800_0000;
            super_start_reg  <= 32'h0000_0000;
            super_active_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MEM_BASE:     mem_base_reg     <= cfg_wdata;
                CFG_KERNEL_END:   kernel_end_reg   <= cfg_wdata;
                CFG_PHYS_TOP:     phys_top_reg     <= cfg_wdata;
                CFG_SUPER_START:  super_start_reg  <= cfg_wdata;
                CFG_SUPER_ACTIVE: super_active_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sequencer and request registers
    logic [1:0]       state_reg, state_next;
    logic [1:0]       kind_reg;
    logic [CPU_W-1:0] cpu_reg;
    logic [31:0]      addr_reg;

    logic in_take;
    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg <= s_tuser;
            cpu_reg  <= CPU_W'(cpu_fold(s_tdata[2:0], NUM_CPUS));
            addr_reg <= s_tdata[34:3];
        end
    end

    // per-CPU list heads: valid bits reset, indexes are payload
    logic [NUM_CPUS-1:0] head_valid_reg;
    logic [PAGE_W-1:0]   head_idx_reg [NUM_CPUS];

    // list source: own CPU, else lowest other CPU with a page
    logic             steal_found;
    logic [CPU_W-1:0] steal_cpu;
    logic [CPU_W-1:0] sel_cpu;
    logic             sel_valid;
    logic [PAGE_W-1:0] sel_idx;

    always_comb begin
        steal_found = 1'b0;
        steal_cpu   = '0;
        for (int i = 0; i < NUM_CPUS; i++) begin
            if (!steal_found && head_valid_reg[i] && CPU_W'(i) != cpu_reg) begin
                steal_found = 1'b1;
                steal_cpu   = CPU_W'(i);
            end
        end
    end

    assign sel_cpu = (kind_reg == REQ_PAGE_ALLOC && !head_valid_reg[cpu_reg])
                     ? steal_cpu : cpu_reg;
    assign sel_valid = head_valid_reg[sel_cpu];
    assign sel_idx   = head_idx_reg[sel_cpu];

    // page free checks
    logic [31:0]       page_off;
    logic [31:0]       page_num;
    logic              bad_page;
    logic              in_pool;
    logic [POOL_W-1:0] pool_end;

    assign pool_end = POOL_W'(super_start_reg) + POOL_SPAN;
    assign page_off = addr_reg - mem_base_reg;
    assign page_num = page_off >> PAGE_SH;
    assign bad_page = (|addr_reg[PAGE_SH-1:0]) || (addr_reg < kernel_end_reg)
                      || (addr_reg >= phys_top_reg) || (addr_reg < mem_base_reg)
                      || (page_num >= 32'(NUM_PAGES));
    assign in_pool  = super_active_reg && (addr_reg >= super_start_reg)
                      && (POOL_W'(addr_reg) < pool_end);

    // superpage pool
    pcpa_sup_res_t sup_res;
    logic          sup_commit;

    pcpa_super_pool #(
        .NUM_SUPER (NUM_SUPER)
    ) u_pool (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .super_start  (super_start_reg),
        .super_active (super_active_reg),
        .pool_end     (pool_end),
        .is_free      (kind_reg == REQ_SUPER_FREE),
        .addr         (addr_reg),
        .commit       (sup_commit),
        .res          (sup_res)
    );

    // status and address for the current item
    logic [2:0]  item_st;
    logic [31:0] item_addr;

    always_comb begin
        item_st   = ST_OK;
        item_addr = '0;
        unique case (kind_reg) inside
            REQ_PAGE_ALLOC: begin
                if (!sel_valid) begin
                    item_st = ST_NONE;
                end else begin
                    item_addr = mem_base_reg + (32'(sel_idx) << PAGE_SH);
                end
            end
            REQ_PAGE_FREE: begin
                if (bad_page) begin
                    item_st = ST_BAD_PAGE;
                end else if (in_pool) begin
                    item_st = ST_IN_POOL;
                end
            end
            REQ_SUPER_ALLOC, REQ_SUPER_FREE: begin
                item_st   = sup_res.status;
                item_addr = sup_res.addr;
            end
            default: ;
        endcase
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    logic [2:0]  out_st_reg;
    logic        out_free;
    logic        pop_go;
    logic        exec_done;
    logic        link_done;

    assign out_free  = !out_valid_reg || m_tready;
    assign pop_go    = (state_reg == S_EXEC) && (kind_reg == REQ_PAGE_ALLOC)
                       && (item_st == ST_OK);
    assign exec_done = (state_reg == S_EXEC) && !pop_go && out_free;
    assign link_done = (state_reg == S_LINK) && out_free;
    assign sup_commit = exec_done
                        && (kind_reg == REQ_SUPER_ALLOC || kind_reg == REQ_SUPER_FREE);

    // next-link memory
    logic                push_go;
    logic [PAGE_W:0]     link_rd_data;

    assign push_go = exec_done && (kind_reg == REQ_PAGE_FREE) && (item_st == ST_OK);

    pcpa_link_ram #(
        .DEPTH  (NUM_PAGES),
        .DATA_W (PAGE_W + 1)
    ) u_links (
        .aclk    (aclk),
        .wr_en   (push_go),
        .wr_addr (page_num[PAGE_W-1:0]),
        .wr_data ({sel_valid, sel_idx}),
        .rd_en   (pop_go),
        .rd_addr (sel_idx),
        .rd_data (link_rd_data)
    );

    // head updates: push on free, pop on completed alloc
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
        end else if (push_go) begin
            head_valid_reg[cpu_reg] <= 1'b1;
        end else if (link_done) begin
            head_valid_reg[sel_cpu] <= link_rd_data[PAGE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (push_go) begin
            head_idx_reg[cpu_reg] <= page_num[PAGE_W-1:0];
        end else if (link_done) begin
            head_idx_reg[sel_cpu] <= link_rd_data[PAGE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_take) state_next = S_EXEC;
            S_EXEC: begin
                if (pop_go) begin
                    state_next = S_LINK;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_LINK: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec_done || link_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done || link_done) begin
            out_addr_reg <= item_addr;
            out_st_reg   <= item_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_st_reg, out_addr_reg};

endmodule

FILE: rtl/pcpa_link_ram.sv
// Next-link memory: one write port, one registered read port.
module pcpa_link_ram
    import pcpa_pkg::*;
#(
    parameter int DEPTH  = PCPA_NUM_PAGES,
    parameter int DATA_W = $clog2(PCPA_NUM_PAGES) + 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/pcpa_super_pool.sv
// Superpage pool: used bits, lowest-free search and free checks.
module pcpa_super_pool
    import pcpa_pkg::*;
#(
    parameter int NUM_SUPER = PCPA_NUM_SUPER
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       super_start,
    input  logic              super_active,
    input  logic [POOL_W-1:0] pool_end,
    input  logic              is_free,
    input  logic [31:0]       addr,
    input  logic              commit,
    output pcpa_sup_res_t     res
);

    localparam int SUP_W = (NUM_SUPER > 1) ? $clog2(NUM_SUPER) : 1;

    logic [NUM_SUPER-1:0] used_reg;
    logic [NUM_SUPER-1:0] used_next;

    logic             free_found;
    logic [SUP_W-1:0] free_idx;
    logic [31:0]      off;
    logic [31:0]      blk;
    logic             out_pool;
    logic             misalign;
    logic             not_used;
    logic [2:0]       alloc_st;
    logic [2:0]       free_st;

    // lowest free block
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NUM_SUPER; i++) begin
            if (!free_found && !used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SUP_W'(i);
            end
        end
    end

    // free checks, in priority order
    assign off      = addr - super_start;
    assign blk      = off >> SUPER_SH;
    assign out_pool = (addr < super_start) || (POOL_W'(addr) >= pool_end);
    assign misalign = |off[SUPER_SH-1:0];
    assign not_used = (blk >= 32'(NUM_SUPER)) || !used_reg[blk[SUP_W-1:0]];

    always_comb begin
        if (!super_active) begin
            alloc_st = ST_INACTIVE;
        end else if (!free_found) begin
            alloc_st = ST_NONE;
        end else begin
            alloc_st = ST_OK;
        end

        if (!super_active) begin
            free_st = ST_INACTIVE;
        end else if (out_pool) begin
            free_st = ST_OUT_POOL;
        end else if (misalign) begin
            free_st = ST_MISALIGN;
        end else if (not_used) begin
            free_st = ST_DOUBLE;
        end else begin
            free_st = ST_OK;
        end
    end

    // answer for the current item
    always_comb begin
        res.status = is_free ? free_st : alloc_st;
        res.addr   = '0;
        if (!is_free && alloc_st == ST_OK) begin
            res.addr = super_start + (32'(free_idx) << SUPER_SH);
        end
    end

    // used bit update on commit
    always_comb begin
        used_next = used_reg;
        if (commit && is_free && free_st == ST_OK) begin
            used_next[blk[SUP_W-1:0]] = 1'b0;
        end else if (commit && !is_free && alloc_st == ST_OK) begin
            used_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

endmodule

FILE: rtl/pcpa_checker.sv
// Port-level checker for the allocator, bound to the top level.
module pcpa_checker
    import pcpa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: intake closes right after an item is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("intake open while item in flight");

    // every failure reports address zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[34:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero address on failed request");

    // a new result needs an item in flight, so intake must have been closed
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without item in flight");

endmodule

bind percpu_page_and_superpage_allocator_unit pcpa_checker u_pcpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
